@@ design/ftm_pkg.sv @@
package ftm_pkg;

  localparam int PHASES  = 3;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int STATE_W = 48;
  localparam int TEMP_W  = 40;
  localparam int GAIN_W  = 16;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 72;
  localparam int VOLT_W  = 16;
  localparam int LEVEL_W = 15;
  localparam int INIT_W  = 32;

  localparam logic [STATE_W-1:0] STATE_MAX = '1;
  localparam logic [TEMP_W-1:0]  TEMP_MAX  = '1;

  typedef enum logic [2:0] {
    REG_FILTER_RATES = 3'd0,
    REG_WEIGHTS      = 3'd1,
    REG_TEMP_LIMIT   = 3'd2,
    REG_ZERO_CURRENT = 3'd3,
    REG_ARC_VOLTAGE  = 3'd4,
    REG_INIT_VALUE   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [DATA_W-1:0]  filter_rates;
    logic [DATA_W-1:0]  weights;
    logic [TEMP_W-1:0]  temp_limit;
    logic [LEVEL_W-1:0] zero_current;
    logic [LEVEL_W-1:0] arc_voltage;
    logic [INIT_W-1:0]  init_value;
  } ftm_cfg_t;

  typedef struct packed {
    logic [PHASES-1:0][TEMP_W-1:0] temperature;
    logic [PHASES-1:0][VOLT_W-1:0] voltage;
    logic [PHASES-1:0]             melt;
    logic [PHASES-1:0]             arc;
    logic [PHASES-1:0]             opened;
  } ftm_result_t;

  function automatic logic [GAIN_W-1:0] lane16(input logic [DATA_W-1:0] packed_word,
                                               input logic [2:0] k);
    if (k[2]) begin
      return '0;
    end
    return packed_word[{k[1:0], 4'b0000} +: GAIN_W];
  endfunction

endpackage

@@ design/three_phase_fuse_thermal_model_top.sv @@
// A new request is accepted only after the previous result has been loaded into the
// output register, which holds until out_ready takes it; each phase lane walks its filters
// through one shared step multiplier and one shared weight multiplier.
// Reset (rst, synchronous): clears all filter states, melt latches and previous currents,
// loads register defaults (temp_limit all ones, others zero) and empties the pipeline.
module three_phase_fuse_thermal_model_top #(
  parameter int FILTERS       = 4,
  parameter int CURRENT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ftm_pkg::ADDR_W-1:0]       paddr,
  input  logic [ftm_pkg::DATA_W-1:0]       pwdata,
  output logic [ftm_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [CURRENT_WIDTH-1:0]  current_a,
  input  logic signed [CURRENT_WIDTH-1:0]  current_b,
  input  logic signed [CURRENT_WIDTH-1:0]  current_c,
  input  logic                             reset_fuse,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ftm_pkg::TEMP_W-1:0]       temperature_a,
  output logic [ftm_pkg::TEMP_W-1:0]       temperature_b,
  output logic [ftm_pkg::TEMP_W-1:0]       temperature_c,
  output logic signed [ftm_pkg::VOLT_W-1:0] voltage_a,
  output logic signed [ftm_pkg::VOLT_W-1:0] voltage_b,
  output logic signed [ftm_pkg::VOLT_W-1:0] voltage_c,
  output logic [ftm_pkg::PHASES-1:0]       melt_flags,
  output logic [ftm_pkg::PHASES-1:0]       arc_flags,
  output logic [ftm_pkg::PHASES-1:0]       open_flags
);
  import ftm_pkg::*;

  ftm_cfg_t                        cfg;
  logic                            cfg_write;
  logic [2:0]                      reg_idx;

  logic                            accept;
  logic                            busy;
  logic                            load;
  logic                            rf_q;
  logic signed [CURRENT_WIDTH-1:0] cur_in [PHASES];
  logic signed [CURRENT_WIDTH-1:0] cur_q [PHASES];
  logic [PHASES-1:0]               lane_done;
  logic [TEMP_W-1:0]               lane_temp [PHASES];
  ftm_result_t                     result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_rates <= '0;
      cfg.weights      <= '0;
      cfg.temp_limit   <= TEMP_MAX;
      cfg.zero_current <= '0;
      cfg.arc_voltage  <= '0;
      cfg.init_value   <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_FILTER_RATES: cfg.filter_rates <= pwdata;
        REG_WEIGHTS:      cfg.weights      <= pwdata;
        REG_TEMP_LIMIT:   cfg.temp_limit   <= pwdata[TEMP_W-1:0];
        REG_ZERO_CURRENT: cfg.zero_current <= pwdata[LEVEL_W-1:0];
        REG_ARC_VOLTAGE:  cfg.arc_voltage  <= pwdata[LEVEL_W-1:0];
        REG_INIT_VALUE:   cfg.init_value   <= pwdata[INIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILTER_RATES: prdata = cfg.filter_rates;
      REG_WEIGHTS:      prdata = cfg.weights;
      REG_TEMP_LIMIT:   prdata = DATA_W'(cfg.temp_limit);
      REG_ZERO_CURRENT: prdata = DATA_W'(cfg.zero_current);
      REG_ARC_VOLTAGE:  prdata = DATA_W'(cfg.arc_voltage);
      REG_INIT_VALUE:   prdata = DATA_W'(cfg.init_value);
      default:          prdata = '0;
    endcase
  end

  assign cur_in[0] = current_a;
  assign cur_in[1] = current_b;
  assign cur_in[2] = current_c;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign load     = busy && (&lane_done) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rf_q <= reset_fuse;
      for (int p = 0; p < PHASES; p++) begin
        cur_q[p] <= cur_in[p];
      end
    end
  end

  for (genvar p = 0; p < PHASES; p++) begin : g_lane
    ftm_lane #(
      .FILTERS       (FILTERS),
      .CURRENT_WIDTH (CURRENT_WIDTH)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .start       (accept),
      .current     (cur_in[p]),
      .reset_fuse  (reset_fuse),
      .cfg         (cfg),
      .done        (lane_done[p]),
      .temperature (lane_temp[p])
    );
  end

  ftm_merge #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .current     (cur_q),
    .temperature (lane_temp),
    .reset_fuse  (rf_q),
    .cfg         (cfg),
    .result      (result)
  );

  assign temperature_a = result.temperature[0];
  assign temperature_b = result.temperature[1];
  assign temperature_c = result.temperature[2];
  assign voltage_a     = result.voltage[0];
  assign voltage_b     = result.voltage[1];
  assign voltage_c     = result.voltage[2];
  assign melt_flags    = result.melt;
  assign arc_flags     = result.arc;
  assign open_flags    = result.opened;

endmodule

@@ design/ftm_lane.sv @@
module ftm_lane #(
  parameter int FILTERS       = 4,
  parameter int CURRENT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [CURRENT_WIDTH-1:0]  current,
  input  logic                             reset_fuse,
  input  ftm_pkg::ftm_cfg_t                cfg,
  output logic                             done,
  output logic [ftm_pkg::TEMP_W-1:0]       temperature
);
  import ftm_pkg::*;

  localparam int KW = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(FILTERS - 1);

  logic [STATE_W-1:0]         state [FILTERS];

  logic [CURRENT_WIDTH-1:0]   mag;
  logic [2*CURRENT_WIDTH-1:0] sq;
  logic [63:0]                sq_wide;
  logic [STATE_W-1:0]         x_next;

  logic [STATE_W-1:0]         x_q;
  logic                       rf_q;
  logic                       issue;
  logic [KW-1:0]              k_a;

  logic [STATE_W-1:0]         s_rd;
  logic                       dn_next;
  logic [STATE_W-1:0]         diff;
  logic [PROD_W-1:0]          prod_next;

  logic                       a_v;
  logic                       a_last;
  logic [KW-1:0]              ka_q;
  logic                       dn_a;
  logic [STATE_W-1:0]         s_a;
  logic [PROD_W-1:0]          prod_a;

  logic [STATE_W:0]           down_step;
  logic [STATE_W-1:0]         snew;

  logic                       b_v;
  logic                       b_last;
  logic [KW-1:0]              kb_q;
  logic [STATE_W-1:0]         snew_q;

  logic                       c_v;
  logic                       c_last;
  logic [PROD_W-1:0]          wprod_q;

  logic [ACC_W-1:0]           acc;

  always_comb begin
    mag     = current[CURRENT_WIDTH-1] ? (~current + 1'b1) : current;
    sq      = mag * mag;
    sq_wide = 64'(sq);
    x_next  = (|sq_wide[63:32]) ? STATE_MAX : {sq_wide[31:0], 16'h0000};
  end

  always_comb begin
    s_rd      = state[k_a];
    dn_next   = x_q < s_rd;
    diff      = dn_next ? (s_rd - x_q) : (x_q - s_rd);
    prod_next = diff * lane16(cfg.filter_rates, 3'(k_a));
  end

  always_comb begin
    down_step = {1'b0, prod_a[PROD_W-1:16]} + (STATE_W + 1)'(|prod_a[15:0]);
    if (rf_q) begin
      snew = {cfg.init_value, 16'h0000};
    end else if (dn_a) begin
      snew = s_a - down_step[STATE_W-1:0];
    end else begin
      snew = s_a + prod_a[PROD_W-1:16];
    end
  end

  assign temperature = (|acc[ACC_W-1:68]) ? TEMP_MAX : acc[67:28];

  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= 1'b0;
      k_a   <= '0;
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      done  <= 1'b0;
      for (int i = 0; i < FILTERS; i++) begin
        state[i] <= '0;
      end
    end else begin
      a_v <= issue;
      b_v <= a_v;
      c_v <= b_v;
      if (start) begin
        issue <= 1'b1;
        k_a   <= '0;
        done  <= 1'b0;
      end else if (issue) begin
        k_a <= k_a + 1'b1;
        if (k_a == K_LAST) begin
          issue <= 1'b0;
        end
      end
      if (b_v) begin
        state[kb_q] <= snew_q;
      end
      if (c_v && c_last) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q  <= x_next;
      rf_q <= reset_fuse;
    end
    a_last <= (k_a == K_LAST);
    ka_q   <= k_a;
    dn_a   <= dn_next;
    s_a    <= s_rd;
    prod_a <= prod_next;
    b_last <= a_last;
    kb_q   <= ka_q;
    if (a_v) begin
      snew_q <= snew;
    end
    c_last  <= b_last;
    wprod_q <= lane16(cfg.weights, 3'(kb_q)) * snew_q;
    if (start) begin
      acc <= '0;
    end else if (c_v) begin
      acc <= acc + ACC_W'(wprod_q);
    end
  end

endmodule

@@ design/ftm_merge.sv @@
module ftm_merge #(
  parameter int CURRENT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic signed [CURRENT_WIDTH-1:0] current [ftm_pkg::PHASES],
  input  logic [ftm_pkg::TEMP_W-1:0]      temperature [ftm_pkg::PHASES],
  input  logic                            reset_fuse,
  input  ftm_pkg::ftm_cfg_t               cfg,
  output ftm_pkg::ftm_result_t            result
);
  import ftm_pkg::*;

  logic [PHASES-1:0]              melt_latched;
  logic signed [CURRENT_WIDTH-1:0] prev [PHASES];

  logic [CURRENT_WIDTH-1:0]       mag [PHASES];
  logic [PHASES-1:0]              same_sign;
  logic [PHASES-1:0]              melt_next;
  logic [PHASES-1:0]              arc_next;
  logic [VOLT_W-1:0]              volt_next [PHASES];
  logic [VOLT_W-1:0]              av_pos;
  logic [VOLT_W-1:0]              av_neg;

  always_comb begin
    av_pos = {1'b0, cfg.arc_voltage};
    av_neg = ~av_pos + 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      mag[p] = current[p][CURRENT_WIDTH-1] ? (~current[p] + 1'b1) : current[p];
      same_sign[p] = !((prev[p] < 0 && current[p] > 0) || (prev[p] > 0 && current[p] < 0));
      melt_next[p] = !reset_fuse && (melt_latched[p] || (temperature[p] > cfg.temp_limit));
      arc_next[p] = melt_next[p] && same_sign[p] &&
                    (32'(mag[p]) > 32'(cfg.zero_current));
      if (!arc_next[p]) begin
        volt_next[p] = '0;
      end else if (current[p] > 0) begin
        volt_next[p] = av_pos;
      end else begin
        volt_next[p] = av_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      melt_latched <= '0;
      for (int p = 0; p < PHASES; p++) begin
        prev[p] <= '0;
      end
    end else if (load) begin
      melt_latched <= melt_next;
      for (int p = 0; p < PHASES; p++) begin
        prev[p] <= current[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < PHASES; p++) begin
        result.temperature[p] <= temperature[p];
        result.voltage[p]     <= volt_next[p];
      end
      result.melt   <= melt_next;
      result.arc    <= arc_next;
      result.opened <= melt_next & ~arc_next;
    end
  end

endmodule

@@ test/fuse_thermal_checker.sv @@
module fuse_thermal_checker #(
  parameter int FILTERS       = 4,
  parameter int CURRENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [ftm_pkg::ADDR_W-1:0]        paddr,
  input  logic [ftm_pkg::DATA_W-1:0]        pwdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [CURRENT_WIDTH-1:0]   current_a,
  input  logic signed [CURRENT_WIDTH-1:0]   current_b,
  input  logic signed [CURRENT_WIDTH-1:0]   current_c,
  input  logic                              reset_fuse,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ftm_pkg::TEMP_W-1:0]        temperature_a,
  input  logic [ftm_pkg::TEMP_W-1:0]        temperature_b,
  input  logic [ftm_pkg::TEMP_W-1:0]        temperature_c,
  input  logic signed [ftm_pkg::VOLT_W-1:0] voltage_a,
  input  logic signed [ftm_pkg::VOLT_W-1:0] voltage_b,
  input  logic signed [ftm_pkg::VOLT_W-1:0] voltage_c,
  input  logic [ftm_pkg::PHASES-1:0]        melt_flags,
  input  logic [ftm_pkg::PHASES-1:0]        arc_flags,
  input  logic [ftm_pkg::PHASES-1:0]        open_flags,
  output int                                mismatches,
  output int                                outstanding
);
  import ftm_pkg::*;

  typedef logic [PHASES-1:0][CURRENT_WIDTH-1:0] tick_currents_t;

  ftm_cfg_t                        settings;
  logic [STATE_W-1:0]              level [PHASES][FILTERS];
  logic                            melted [PHASES];
  logic signed [CURRENT_WIDTH-1:0] last_current [PHASES];
  ftm_result_t                     pending_results [$];
  string                           phase_tag [PHASES] = '{"a", "b", "c"};

  function automatic void check_field(input string name, input longint want,
                                      input longint actual);
    if (want != actual) begin
      $error("%s expected %0d got %0d", name, want, actual);
      mismatches++;
    end
  endfunction

  function automatic ftm_result_t heat_tick(input tick_currents_t cur, input logic restore);
    ftm_result_t        r;
    longint             amps;
    longint             mag;
    logic [STATE_W-1:0] target;
    logic [79:0]        step;
    logic [79:0]        heat;
    logic [TEMP_W-1:0]  temp;
    logic               melt;
    logic               arc;
    logic               same_sign;
    r = '0;
    for (int p = 0; p < PHASES; p++) begin
      amps = longint'($signed(cur[p]));
      mag = (amps < 0) ? -amps : amps;
      target = STATE_W'(mag * mag) << 16;
      heat = '0;
      for (int k = 0; k < FILTERS; k++) begin
        if (restore) begin
          level[p][k] = STATE_W'(settings.init_value) << 16;
        end else if (target >= level[p][k]) begin
          step = 80'(target - level[p][k]) * 80'(settings.filter_rates[16*k +: 16]);
          level[p][k] = level[p][k] + STATE_W'(step >> 16);
        end else begin
          step = 80'(level[p][k] - target) * 80'(settings.filter_rates[16*k +: 16])
                 + 80'hFFFF;
          level[p][k] = level[p][k] - STATE_W'(step >> 16);
        end
        heat += 80'(settings.weights[16*k +: 16]) * 80'(level[p][k]);
      end
      heat = heat >> 28;
      temp = (heat > 80'(TEMP_MAX)) ? TEMP_MAX : TEMP_W'(heat);
      melt = !restore && (melted[p] || temp > settings.temp_limit);
      melted[p] = melt;
      same_sign = !((last_current[p] < 0 && amps > 0) || (last_current[p] > 0 && amps < 0));
      arc = melt && same_sign && (mag > longint'(settings.zero_current));
      r.temperature[p] = temp;
      if (!arc) begin
        r.voltage[p] = '0;
      end else if (amps > 0) begin
        r.voltage[p] = VOLT_W'(settings.arc_voltage);
      end else begin
        r.voltage[p] = VOLT_W'(-longint'(settings.arc_voltage));
      end
      r.melt[p] = melt;
      r.arc[p] = arc;
      r.opened[p] = melt && !arc;
      last_current[p] = $signed(cur[p]);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ftm_result_t actual;
    ftm_result_t want;
    if (rst) begin
      settings = '0;
      settings.temp_limit = TEMP_MAX;
      for (int p = 0; p < PHASES; p++) begin
        for (int k = 0; k < FILTERS; k++) begin
          level[p][k] = '0;
        end
        melted[p] = 1'b0;
        last_current[p] = '0;
      end
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:3])
          REG_FILTER_RATES: settings.filter_rates = pwdata;
          REG_WEIGHTS:      settings.weights = pwdata;
          REG_TEMP_LIMIT:   settings.temp_limit = pwdata[TEMP_W-1:0];
          REG_ZERO_CURRENT: settings.zero_current = pwdata[LEVEL_W-1:0];
          REG_ARC_VOLTAGE:  settings.arc_voltage = pwdata[LEVEL_W-1:0];
          REG_INIT_VALUE:   settings.init_value = pwdata[INIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(heat_tick({current_c, current_b, current_a}, reset_fuse));
      end
      if (out_valid && out_ready) begin
        actual.temperature = {temperature_c, temperature_b, temperature_a};
        actual.voltage = {voltage_c, voltage_b, voltage_a};
        actual.melt = melt_flags;
        actual.arc = arc_flags;
        actual.opened = open_flags;
        if (pending_results.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          for (int p = 0; p < PHASES; p++) begin
            check_field({"temperature_", phase_tag[p]}, longint'(want.temperature[p]),
                        longint'(actual.temperature[p]));
            check_field({"voltage_", phase_tag[p]}, longint'($signed(want.voltage[p])),
                        longint'($signed(actual.voltage[p])));
          end
          check_field("melt_flags", longint'(want.melt), longint'(actual.melt));
          check_field("arc_flags", longint'(want.arc), longint'(actual.arc));
          check_field("open_flags", longint'(want.opened), longint'(actual.opened));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import ftm_pkg::*;

  localparam int         CUR_W      = 16;
  localparam logic [2:0] SPARE_SLOT = 3'd6;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic                     pready;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [CUR_W-1:0]  current_a;
  logic signed [CUR_W-1:0]  current_b;
  logic signed [CUR_W-1:0]  current_c;
  logic                     reset_fuse;
  logic                     out_valid;
  logic                     out_ready;
  logic [TEMP_W-1:0]        temperature_a;
  logic [TEMP_W-1:0]        temperature_b;
  logic [TEMP_W-1:0]        temperature_c;
  logic signed [VOLT_W-1:0] voltage_a;
  logic signed [VOLT_W-1:0] voltage_b;
  logic signed [VOLT_W-1:0] voltage_c;
  logic [PHASES-1:0]        melt_flags;
  logic [PHASES-1:0]        arc_flags;
  logic [PHASES-1:0]        open_flags;
  int                       mismatches;
  int                       outstanding;
  int                       sent;
  int                       delivered;
  logic                     squeeze_req;
  bit [PHASES-1:0]          polarity;

  three_phase_fuse_thermal_model_top dut (.*);

  fuse_thermal_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      delivered <= 0;
    end else if (out_valid && out_ready) begin
      delivered <= delivered + 1;
    end
  end

  initial begin : receiver
    int  span;
    int  mode;
    bit  squeezed;
    out_ready = 1'b0;
    span = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        // hold off long enough for the block to back up into its input
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(negedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(80, 20);
          mode = $urandom_range(3);
        end
        span--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(3) != 0);
          2: out_ready <= 1'($urandom_range(1));
          default: out_ready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [2:0] slot, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {slot, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic offer_tick(input logic [CUR_W-1:0] a, input logic [CUR_W-1:0] b,
                            input logic [CUR_W-1:0] c, input logic restore);
    @(negedge clk);
    in_valid <= 1'b1;
    current_a <= a;
    current_b <= b;
    current_c <= c;
    reset_fuse <= restore;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (delivered != sent) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] spread(input logic [DATA_W-1:0] ceiling);
    case ($urandom_range(3))
      0: return '0;
      1: return ceiling;
      default: return {$urandom, $urandom} & ceiling;
    endcase
  endfunction

  task automatic program_random_setting();
    logic [TEMP_W-1:0] limit;
    case ($urandom_range(7))
      0: limit = '0;
      1: limit = TEMP_MAX;
      default: limit = TEMP_W'(64'($urandom) << $urandom_range(2));
    endcase
    write_reg(REG_FILTER_RATES, spread('1));
    write_reg(REG_WEIGHTS, spread('1));
    write_reg(REG_TEMP_LIMIT, DATA_W'(limit));
    write_reg(REG_ZERO_CURRENT, spread(64'h7FFF));
    write_reg(REG_ARC_VOLTAGE, spread(64'h7FFF));
    write_reg(REG_INIT_VALUE, spread(64'hFFFF_FFFF));
  endtask

  task automatic random_tick();
    logic [PHASES-1:0][CUR_W-1:0] amps;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(15))
        0: begin
          case ($urandom_range(4))
            0: amps[p] = 16'h8000;
            1: amps[p] = 16'h7FFF;
            2: amps[p] = 16'h0000;
            3: amps[p] = 16'hFFFF;
            default: amps[p] = 16'h0001;
          endcase
        end
        1: amps[p] = CUR_W'($urandom);
        default: begin
          // keep the sign for a while so that arcs can persist
          if ($urandom_range(7) == 0) polarity[p] = ~polarity[p];
          amps[p] = CUR_W'($urandom_range(32767));
          if (polarity[p]) amps[p] = -amps[p];
        end
      endcase
    end
    offer_tick(amps[0], amps[1], amps[2], $urandom_range(39) == 0);
  endtask

  initial begin : stimulus
    int left;
    int burst;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    current_a = '0;
    current_b = '0;
    current_c = '0;
    reset_fuse = 1'b0;
    squeeze_req = 1'b0;
    sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_FILTER_RATES, '0);
    write_reg(REG_WEIGHTS, '0);
    write_reg(REG_TEMP_LIMIT, DATA_W'(TEMP_MAX));
    write_reg(REG_ZERO_CURRENT, '0);
    write_reg(REG_ARC_VOLTAGE, '0);
    write_reg(REG_INIT_VALUE, '0);
    offer_tick(16'h0000, 16'h0000, 16'h0000, 1'b0);
    offer_tick(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    offer_tick(16'h8000, 16'h7FFF, 16'h0001, 1'b0);
    offer_tick(16'hFFFF, 16'h0001, 16'h0000, 1'b0);
    drain();

    write_reg(REG_FILTER_RATES, '1);
    write_reg(REG_WEIGHTS, '1);
    write_reg(REG_TEMP_LIMIT, '0);
    write_reg(REG_ZERO_CURRENT, '0);
    write_reg(REG_ARC_VOLTAGE, 64'h7FFF);
    write_reg(REG_INIT_VALUE, 64'hFFFF_FFFF);
    write_reg(SPARE_SLOT, {$urandom, $urandom});
    offer_tick(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
    offer_tick(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    offer_tick(16'hFFFF, 16'h0001, 16'h0001, 1'b0);
    offer_tick(16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
    offer_tick(16'h0000, 16'h0000, 16'h0000, 1'b0);
    offer_tick(16'hFFFF, 16'h0001, 16'h8000, 1'b0);
    offer_tick(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
    offer_tick(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    offer_tick(16'h5555, 16'hAAAA, 16'h0F0F, 1'b0);
    offer_tick(16'hAAAA, 16'h5555, 16'hF0F0, 1'b0);
    drain();

    for (int setting = 0; setting < 7; setting++) begin
      if (setting == 6) begin
        write_reg(REG_FILTER_RATES, '0);
        write_reg(REG_WEIGHTS, '1);
        write_reg(REG_TEMP_LIMIT, '0);
        write_reg(REG_ZERO_CURRENT, 64'h7FFF);
        write_reg(REG_ARC_VOLTAGE, '0);
        write_reg(REG_INIT_VALUE, 64'hFFFF_FFFF);
      end else begin
        program_random_setting();
      end
      if (setting == 0) begin
        @(negedge clk);
        squeeze_req <= 1'b1;
      end
      left = 140;
      while (left > 0) begin
        burst = $urandom_range(24, 1);
        for (int j = 0; j < burst && left > 0; j++) begin
          random_tick();
          left--;
        end
        if ($urandom_range(3) != 0) pause_sender($urandom_range(8, 1));
      end
      drain();
    end

    repeat (12) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
